// ===== sv/tilt_angle_motor_trigger_core_assert.svh =====
// Assertion macros used by the checker file.
`ifndef TILT_ANGLE_MOTOR_TRIGGER_CORE_ASSERT_SVH
`define TILT_ANGLE_MOTOR_TRIGGER_CORE_ASSERT_SVH

// Clocked check, masked while reset is high.
`define TAMT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also runs through reset.
`define TAMT_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/tamt_pkg.sv =====
package tamt_pkg;

  localparam int ACCEL_W     = 16;
  localparam int CFG_W       = 9;
  localparam int CFG_IDX_W   = 1;
  localparam int ANGLE_W     = 15;
  localparam int XY_W        = 33;   // samples scaled by 2^14, plus CORDIC gain
  localparam int ACC_W       = 26;   // angle in 2^-16 degree
  localparam int ROUND_SHIFT = 10;
  localparam int RND_W       = ACC_W - ROUND_SHIFT;
  localparam int TABLE_LEN   = 24;
  localparam int CORDIC_STAGES_DEF = 16;

  localparam logic [CFG_IDX_W-1:0] REG_LOWER = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER = 1'd1;

  localparam logic signed [CFG_W-1:0] LOWER_RESET = 9'sd90;
  localparam logic signed [CFG_W-1:0] UPPER_RESET = 9'sd0;

  localparam logic signed [ACC_W-1:0] HALF_TURN   = 26'sd11796480;
  localparam logic signed [ACC_W-1:0] ROUND_HALF  = 26'sd512;
  localparam logic signed [RND_W-1:0] ANGLE_MAX_R = 16'sd11520;
  localparam logic signed [RND_W-1:0] ANGLE_MIN_R = -16'sd11520;
  localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = 15'sd11520;
  localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = -15'sd11520;
  localparam logic signed [ANGLE_W-1:0] MINUS_NINETY = -15'sd5760;

  // atan(2^-i) in degrees times 2^16, rounded
  localparam logic signed [ACC_W-1:0] ATAN_TAB [0:TABLE_LEN-1] = '{
    26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945, 26'sd234379, 26'sd117304,
    26'sd58666, 26'sd29335, 26'sd14668, 26'sd7334, 26'sd3667, 26'sd1833,
    26'sd917, 26'sd458, 26'sd229, 26'sd115, 26'sd57, 26'sd29,
    26'sd14, 26'sd7, 26'sd4, 26'sd2, 26'sd1, 26'sd0
  };

  typedef struct packed {
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [ACC_W-1:0] acc;
    logic                    zero;
  } tamt_vec_t;

endpackage

// ===== sv/tamt_ifs.sv =====
interface tamt_in_if;
  import tamt_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [ACCEL_W-1:0] accel_y;
  logic signed [ACCEL_W-1:0] accel_z;
  modport source (output valid, accel_y, accel_z, input ready);
  modport sink   (input valid, accel_y, accel_z, output ready);
endinterface

interface tamt_out_if;
  import tamt_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [ANGLE_W-1:0] tilt_angle;
  logic                      motor_one_on;
  logic                      motor_two_on;
  modport source (output valid, tilt_angle, motor_one_on, motor_two_on, input ready);
  modport sink   (input valid, tilt_angle, motor_one_on, motor_two_on, output ready);
endinterface

interface tamt_cfg_if;
  import tamt_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/tamt_cfg_regs.sv =====
module tamt_cfg_regs (
  input  logic                               clk,
  input  logic                               rst,
  tamt_cfg_if.sink                           cfg,
  output logic signed [tamt_pkg::CFG_W-1:0]  lower_angle,
  output logic signed [tamt_pkg::CFG_W-1:0]  upper_angle
);
  import tamt_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lower_angle <= LOWER_RESET;
      upper_angle <= UPPER_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_LOWER: lower_angle <= cfg.data;
        REG_UPPER: upper_angle <= cfg.data;
      endcase
    end
  end

endmodule

// ===== sv/tamt_prep.sv =====
module tamt_prep (
  input  logic                 clk,
  input  logic                 rst,
  tamt_in_if.sink              sample,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tamt_pkg::tamt_vec_t  out_vec
);
  import tamt_pkg::*;

  localparam int PAD_W = XY_W - ACCEL_W - 14;

  logic                    valid;
  tamt_vec_t               vec;
  tamt_vec_t               vec_next;
  logic signed [XY_W-1:0]  x_raw;
  logic signed [XY_W-1:0]  y_raw;

  assign sample.ready = !valid || out_ready;

  // fold the left half-plane onto the right and preload +-180 degrees
  always_comb begin
    x_raw = {{PAD_W{sample.accel_z[ACCEL_W-1]}}, sample.accel_z, 14'b0};
    y_raw = {{PAD_W{sample.accel_y[ACCEL_W-1]}}, sample.accel_y, 14'b0};
    vec_next.zero = (sample.accel_y == '0) && (sample.accel_z == '0);
    if (sample.accel_z[ACCEL_W-1]) begin
      vec_next.x   = -x_raw;
      vec_next.y   = -y_raw;
      vec_next.acc = sample.accel_y[ACCEL_W-1] ? -HALF_TURN : HALF_TURN;
    end else begin
      vec_next.x   = x_raw;
      vec_next.y   = y_raw;
      vec_next.acc = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (sample.ready) begin
      valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      vec <= vec_next;
    end
  end

  assign out_valid = valid;
  assign out_vec   = vec;

endmodule

// ===== sv/tamt_cordic_stage.sv =====
module tamt_cordic_stage #(
  parameter int SHIFT = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tamt_pkg::tamt_vec_t  in_vec,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tamt_pkg::tamt_vec_t  out_vec
);
  import tamt_pkg::*;

  logic                    valid;
  tamt_vec_t               vec;
  tamt_vec_t               vec_next;
  logic signed [XY_W-1:0]  x_sh;
  logic signed [XY_W-1:0]  y_sh;

  assign in_ready = !valid || out_ready;

  // rotate toward the x axis; non-negative y adds the table angle
  always_comb begin
    x_sh = in_vec.x >>> SHIFT;
    y_sh = in_vec.y >>> SHIFT;
    vec_next.zero = in_vec.zero;
    if (!in_vec.y[XY_W-1]) begin
      vec_next.x   = in_vec.x + y_sh;
      vec_next.y   = in_vec.y - x_sh;
      vec_next.acc = in_vec.acc + ATAN_TAB[SHIFT];
    end else begin
      vec_next.x   = in_vec.x - y_sh;
      vec_next.y   = in_vec.y + x_sh;
      vec_next.acc = in_vec.acc - ATAN_TAB[SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      vec <= vec_next;
    end
  end

  assign out_valid = valid;
  assign out_vec   = vec;

endmodule

// ===== sv/tamt_result.sv =====
module tamt_result (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  tamt_pkg::tamt_vec_t                in_vec,
  input  logic signed [tamt_pkg::CFG_W-1:0]  lower_angle,
  input  logic signed [tamt_pkg::CFG_W-1:0]  upper_angle,
  tamt_out_if.source                         result
);
  import tamt_pkg::*;

  logic                      valid;
  logic signed [ANGLE_W-1:0] angle;
  logic                      motor_one;
  logic                      motor_two;
  logic signed [ACC_W-1:0]   acc_rnd;
  logic signed [RND_W-1:0]   angle_r;
  logic signed [ANGLE_W-1:0] angle_next;
  logic signed [ANGLE_W-1:0] lower_64;
  logic signed [ANGLE_W-1:0] upper_64;

  assign in_ready = !valid || result.ready;

  // round half up to 1/64 degree, then clamp to a half turn; an all-zero sample gives 0
  always_comb begin
    acc_rnd  = in_vec.acc + ROUND_HALF;
    angle_r  = acc_rnd[ACC_W-1:ROUND_SHIFT];
    lower_64 = {lower_angle, 6'b0};
    upper_64 = {upper_angle, 6'b0};
    if (in_vec.zero) begin
      angle_next = '0;
    end else if (angle_r > ANGLE_MAX_R) begin
      angle_next = ANGLE_MAX;
    end else if (angle_r < ANGLE_MIN_R) begin
      angle_next = ANGLE_MIN;
    end else begin
      angle_next = angle_r[ANGLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      angle     <= angle_next;
      motor_one <= (angle_next > lower_64) && (angle_next < ANGLE_MAX);
      motor_two <= (angle_next > MINUS_NINETY) && (angle_next < upper_64);
    end
  end

  assign result.valid        = valid;
  assign result.tilt_angle   = angle;
  assign result.motor_one_on = motor_one;
  assign result.motor_two_on = motor_two;

endmodule

// ===== sv/tilt_angle_motor_trigger_core.sv =====
// A sample pair passes the input fold register, one register per CORDIC
// rotation and the result register; each rotation stage holds its own item.
// Throughput: one item per cycle while the result side does not stall.
// Stages beyond the 24-entry arctangent table are not built.
// Reset (synchronous, rst high) empties the pipeline and loads lower_angle 90,
// upper_angle 0.
module tilt_angle_motor_trigger_core #(
  parameter int CORDIC_STAGES = tamt_pkg::CORDIC_STAGES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  tamt_in_if.sink     sample,
  tamt_out_if.source  result,
  tamt_cfg_if.sink    cfg
);
  import tamt_pkg::*;

  localparam int NSTAGE = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;

  logic signed [CFG_W-1:0] lower_angle;
  logic signed [CFG_W-1:0] upper_angle;
  logic                    vld [0:NSTAGE];
  logic                    rdy [0:NSTAGE];
  tamt_vec_t               vec [0:NSTAGE];

  tamt_cfg_regs u_cfg (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .lower_angle (lower_angle),
    .upper_angle (upper_angle)
  );

  tamt_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample),
    .out_valid (vld[0]),
    .out_ready (rdy[0]),
    .out_vec   (vec[0])
  );

  for (genvar k = 0; k < NSTAGE; k++) begin : g_stage
    tamt_cordic_stage #(
      .SHIFT (k)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (vld[k]),
      .in_ready  (rdy[k]),
      .in_vec    (vec[k]),
      .out_valid (vld[k+1]),
      .out_ready (rdy[k+1]),
      .out_vec   (vec[k+1])
    );
  end

  tamt_result u_result (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (vld[NSTAGE]),
    .in_ready    (rdy[NSTAGE]),
    .in_vec      (vec[NSTAGE]),
    .lower_angle (lower_angle),
    .upper_angle (upper_angle),
    .result      (result)
  );

endmodule

// ===== sv/tamt_checker.sv =====
`include "tilt_angle_motor_trigger_core_assert.svh"

module tamt_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic signed [tamt_pkg::ANGLE_W-1:0]   tilt_angle,
  input logic                                  motor_one_on,
  input logic                                  motor_two_on
);
  import tamt_pkg::*;

  // a held result keeps its payload
  `TAMT_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(tilt_angle) && $stable(motor_one_on) && $stable(motor_two_on)), "result changed while stalled")

  `TAMT_ASSERT_RST(a_rst_empty, rst |=> !out_valid, "result valid right after reset")

  `TAMT_ASSERT(a_angle_range, out_valid |-> (tilt_angle >= ANGLE_MIN && tilt_angle <= ANGLE_MAX), "tilt angle out of range")

  `TAMT_ASSERT(a_motor_bounds, out_valid |-> ((!motor_one_on || tilt_angle < ANGLE_MAX) && (!motor_two_on || tilt_angle > MINUS_NINETY)), "motor enable outside its fixed bound")

endmodule

bind tilt_angle_motor_trigger_core tamt_checker u_tamt_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .tilt_angle   (result.tilt_angle),
  .motor_one_on (result.motor_one_on),
  .motor_two_on (result.motor_two_on)
);

// ===== tb/sv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tamt_pkg::*;

  localparam int LATENCY         = CORDIC_STAGES_DEF + 2;
  localparam int PHASES          = 9;
  localparam int RANDOM_PER_PASS = 100;
  localparam int MAX_REPORTS     = 10;

  typedef struct {
    int                        y;
    int                        z;
    logic signed [ANGLE_W-1:0] angle;
    logic                      motor_one;
    logic                      motor_two;
  } tilt_expect_t;

  class tilt_scoreboard;
    int           lower_deg = int'(LOWER_RESET);
    int           upper_deg = int'(UPPER_RESET);
    tilt_expect_t angle_q[$];
    int           failures;
    int           checked;
    int           motor_one_hits;
    int           motor_two_hits;

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx == REG_LOWER) begin
        lower_deg = int'($signed(data));
      end else if (idx == REG_UPPER) begin
        upper_deg = int'($signed(data));
      end
    endfunction

    // Vectoring CORDIC on the sample pair, angle in 1/64 degree
    function int tilt_of(int y, int z);
      longint xv, yv, acc, xs, ys;
      int     stages;
      int     a;
      if (y == 0 && z == 0) return 0;
      xv  = longint'(z) * 16384;
      yv  = longint'(y) * 16384;
      acc = 0;
      if (z < 0) begin
        acc = (y >= 0) ? longint'(HALF_TURN) : -longint'(HALF_TURN);
        xv  = -xv;
        yv  = -yv;
      end
      stages = (CORDIC_STAGES_DEF > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES_DEF;
      for (int i = 0; i < stages; i++) begin
        xs = xv >>> i;
        ys = yv >>> i;
        if (yv >= 0) begin
          xv  = xv + ys;
          yv  = yv - xs;
          acc = acc + longint'(ATAN_TAB[i]);
        end else begin
          xv  = xv - ys;
          yv  = yv + xs;
          acc = acc - longint'(ATAN_TAB[i]);
        end
      end
      a = int'((acc + longint'(ROUND_HALF)) >>> ROUND_SHIFT);
      if (a > int'(ANGLE_MAX)) a = int'(ANGLE_MAX);
      if (a < int'(ANGLE_MIN)) a = int'(ANGLE_MIN);
      return a;
    endfunction

    function void note_sample(int y, int z);
      tilt_expect_t e;
      int           a;
      a = tilt_of(y, z);
      e.y         = y;
      e.z         = z;
      e.angle     = a[ANGLE_W-1:0];
      e.motor_one = (a > lower_deg * 64) && (a < int'(ANGLE_MAX));
      e.motor_two = (a > int'(MINUS_NINETY)) && (a < upper_deg * 64);
      angle_q.push_back(e);
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= MAX_REPORTS) $display("ERROR: %s", msg);
    endfunction

    function void check_result(logic signed [ANGLE_W-1:0] angle, logic m1, logic m2);
      tilt_expect_t e;
      if (angle_q.size() == 0) begin
        flag($sformatf("result with nothing pending: angle %0d m1 %b m2 %b",
                       angle, m1, m2));
        return;
      end
      e = angle_q.pop_front();
      checked++;
      if (e.motor_one) motor_one_hits++;
      if (e.motor_two) motor_two_hits++;
      if (angle !== e.angle || m1 !== e.motor_one || m2 !== e.motor_two)
        flag($sformatf({"y %0d z %0d (lower %0d upper %0d): expected angle %0d m1 %b m2 %b,",
                        " got angle %0d m1 %b m2 %b"}, e.y, e.z, lower_deg, upper_deg,
                       e.angle, e.motor_one, e.motor_two, angle, m1, m2));
    endfunction

    function int pending();
      return angle_q.size();
    endfunction

    function void drain_check();
      if (angle_q.size() != 0)
        flag($sformatf("%0d results never arrived", angle_q.size()));
    endfunction
  endclass

  logic clk;
  logic rst;

  tamt_in_if  sample_ch();
  tamt_out_if result_ch();
  tamt_cfg_if cfg_ch();

  tilt_angle_motor_trigger_core uut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  tilt_scoreboard sb = new();
  bit idle_on;
  int stall_left;
  int samples_sent;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) sb.set_reg(cfg_ch.index, cfg_ch.data);
      if (sample_ch.valid && sample_ch.ready)
        sb.note_sample(int'(sample_ch.accel_y), int'(sample_ch.accel_z));
      if (result_ch.valid && result_ch.ready)
        sb.check_result(result_ch.tilt_angle, result_ch.motor_one_on,
                        result_ch.motor_two_on);
    end
  end

  // Back-pressure on the result side
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      result_ch.ready <= 1'b0;
    end else begin
      stall_left = (idle_on && $urandom_range(0, 99) < 35) ? gap_len() : 0;
      if (stall_left > 0) begin
        stall_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_pair(int y, int z);
    int gap;
    gap = (idle_on && $urandom_range(0, 99) < 35) ? gap_len() : 0;
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid   <= 1'b1;
    sample_ch.accel_y <= y[ACCEL_W-1:0];
    sample_ch.accel_z <= z[ACCEL_W-1:0];
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    samples_sent++;
  endtask

  // Leave valid high after the write; the caller drops it
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    int gap;
    gap = idle_on ? gap_len() : 0;
    if (gap > 0) begin
      cfg_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val[CFG_W-1:0];
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  // Drop valid, then hold until the pipeline has emptied
  task automatic wait_idle();
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic send_edge_cases();
    send_pair(0, 0);
    send_pair(0, 1);
    send_pair(0, -1);
    send_pair(1, 0);
    send_pair(-1, 0);
    send_pair(32767, 0);
    send_pair(-32768, 0);
    send_pair(0, 32767);
    send_pair(0, -32768);
    send_pair(32767, 32767);
    send_pair(-32768, -32768);
    send_pair(32767, -32768);
    send_pair(-32768, 32767);
    send_pair(1, 1);
    send_pair(-1, 1);
    send_pair(-1, -1);
    send_pair(1, -1);
    send_pair(-1, -32768);
    send_pair(1, -32768);
    send_pair(100, 173);
    send_pair(-32768, 1);
    send_pair(32767, 1);
    send_pair(5, -32768);
  endtask

  task automatic send_random_pair();
    int r, y, z, m;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      y = int'($urandom_range(0, 65535)) - 32768;
      z = int'($urandom_range(0, 65535)) - 32768;
    end else if (r < 65) begin
      y = int'($urandom_range(0, 8)) - 4;
      z = int'($urandom_range(0, 8)) - 4;
    end else if (r < 85) begin
      // axes and diagonals
      m = $urandom_range(1, 32767);
      case ($urandom_range(0, 5))
        0: begin y = 0;  z = $urandom_range(0, 1) ? m : -m; end
        1: begin y = $urandom_range(0, 1) ? m : -m; z = 0; end
        2: begin y = m;  z = m; end
        3: begin y = -m; z = m; end
        4: begin y = m;  z = -m; end
        default: begin y = -m; z = -m; end
      endcase
    end else begin
      y = $urandom_range(0, 1) ? 32767 : -32768;
      z = int'($urandom_range(0, 65535)) - 32768;
      if ($urandom_range(0, 1)) begin
        m = y;
        y = z;
        z = m;
      end
    end
    send_pair(y, z);
  endtask

  initial begin
    int lower_set[PHASES];
    int upper_set[PHASES];
    lower_set = '{90, -180, 180, -256, 255, 0, -90, 0, 0};
    upper_set = '{0, 180, -180, 255, -256, 90, -90, 0, 0};
    lower_set[PHASES-2] = int'($urandom_range(0, 360)) - 180;
    upper_set[PHASES-2] = int'($urandom_range(0, 360)) - 180;
    lower_set[PHASES-1] = int'($urandom_range(0, 511)) - 256;
    upper_set[PHASES-1] = int'($urandom_range(0, 511)) - 256;

    rst               = 1'b1;
    idle_on           = 1'b0;
    stall_left        = 0;
    samples_sent      = 0;
    sample_ch.valid   = 1'b0;
    sample_ch.accel_y = '0;
    sample_ch.accel_z = '0;
    result_ch.ready   = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = REG_LOWER;
    cfg_ch.data       = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // First pass runs on the reset register values
    for (int p = 0; p < PHASES; p++) begin
      idle_on = (p % 3 != 2);
      if (p > 0) begin
        if ($urandom_range(0, 1)) begin
          write_reg(REG_LOWER, lower_set[p]);
          write_reg(REG_UPPER, upper_set[p]);
        end else begin
          write_reg(REG_UPPER, upper_set[p]);
          write_reg(REG_LOWER, lower_set[p]);
        end
        cfg_ch.valid <= 1'b0;
      end
      send_edge_cases();
      repeat (RANDOM_PER_PASS) send_random_pair();
      wait_idle();
    end

    sb.drain_check();
    $display("Sent %0d sample pairs under %0d register settings, %0d results checked",
             samples_sent, PHASES, sb.checked);
    $display("Motor one expected on %0d times, motor two %0d times",
             sb.motor_one_hits, sb.motor_two_hits);
    if (sb.failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d failures", sb.failures);
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d results pending", sb.pending());
    $display("Regression FAIL");
    $finish;
  end

endmodule
